FILE: design/nnd_pkg.sv
// ----------------------------------------------------------------------------
// nnd_pkg
// Shared types, constants and helpers of the nearest-neighbor downscaler:
// register indexes, sizes, divider job codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package nnd_pkg;

	// Largest effective image dimension
	localparam logic [31:0] MAX_DIM = 32'd4096;

	// Field widths
	localparam int CFG_W   = 13;
	localparam int PIX_W   = 32;
	localparam int COORD_W = 12;
	localparam int IDX_W   = 4;

	// Divider sizes: dividend is a counter times a dimension
	localparam int DVD_W = 2 * CFG_W;
	localparam int CNT_W = $clog2(DVD_W + 1);

	// Reset value of every size register
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4096);

	// Register indexes
	localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_DST_WIDTH  = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_DST_HEIGHT = IDX_W'(3);

	// Divider jobs run after reset or a size change
	typedef enum logic [1:0] {
		JOB_COL_STEP,
		JOB_ROW_STEP,
		JOB_COL_CUR,
		JOB_ROW_CUR
	} job_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_RUN,
		ST_START,
		ST_WAIT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic run;
		logic clear_dirty;
		logic div_start;
		logic commit;
		job_t job;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic dirty;
		logic div_done;
	} dp_stat_t;

	// Zero counts as one, anything above hi counts as hi
	function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
		input logic [31:0] hi);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if ({{(32-CFG_W){1'b0}}, v} > hi) begin
			r = hi[CFG_W-1:0];
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

FILE: design/nnd_div.sv
// ----------------------------------------------------------------------------
// nnd_div
// Restoring radix-2 divider: one quotient bit per cycle over all DVD_W
// dividend bits, one-cycle done pulse with quotient and remainder held after.
// ----------------------------------------------------------------------------
module nnd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [nnd_pkg::DVD_W-1:0]   dividend,
	input  logic [nnd_pkg::CFG_W-1:0]   divisor,
	output logic                        done,
	output logic [nnd_pkg::DVD_W-1:0]   quotient,
	output logic [nnd_pkg::CFG_W-1:0]   remainder
);

	logic                        busy_q;
	logic                        done_q;
	logic [nnd_pkg::CNT_W-1:0]   cnt_q;
	logic [nnd_pkg::DVD_W-1:0]   dvd_q;
	logic [nnd_pkg::CFG_W-1:0]   rem_q;
	logic [nnd_pkg::CFG_W-1:0]   dsr_q;

	logic [nnd_pkg::CFG_W:0]     rem_sh;
	logic                        ge;
	logic [nnd_pkg::CFG_W:0]     rem_diff;

	// Shift in the next dividend bit and try the subtract
	always_comb begin
		rem_sh   = {rem_q, dvd_q[nnd_pkg::DVD_W-1]};
		ge       = rem_sh >= {1'b0, dsr_q};
		rem_diff = rem_sh - {1'b0, dsr_q};
	end

	// Control: count the bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nnd_pkg::CNT_W'(nnd_pkg::DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - nnd_pkg::CNT_W'(1);
				if (cnt_q == nnd_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operands, then one restoring step per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[nnd_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? rem_diff[nnd_pkg::CFG_W-1:0] : rem_sh[nnd_pkg::CFG_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

FILE: design/nnd_ctrl.sv
// ----------------------------------------------------------------------------
// nnd_ctrl
// Controller: lets pixels through while the mapping is current; after reset
// or a size write it runs the four divider jobs that rebuild the mapping.
// ----------------------------------------------------------------------------
module nnd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nnd_pkg::dp_stat_t    stat,
	output nnd_pkg::ctrl_cmd_t   cmd
);

	nnd_pkg::state_t state_q, state_d;
	nnd_pkg::job_t   job_q, job_d;

	// State and job registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nnd_pkg::ST_RUN;
			job_q   <= nnd_pkg::JOB_COL_STEP;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d         = state_q;
		job_d           = job_q;
		cmd.run         = 1'b0;
		cmd.clear_dirty = 1'b0;
		cmd.div_start   = 1'b0;
		cmd.commit      = 1'b0;
		cmd.job         = job_q;
		case (state_q)
			nnd_pkg::ST_RUN: begin
				if (stat.dirty) begin
					cmd.clear_dirty = 1'b1;
					job_d           = nnd_pkg::JOB_COL_STEP;
					state_d         = nnd_pkg::ST_START;
				end else begin
					cmd.run = 1'b1;
				end
			end
			nnd_pkg::ST_START: begin
				cmd.div_start = 1'b1;
				state_d       = nnd_pkg::ST_WAIT;
			end
			nnd_pkg::ST_WAIT: begin
				if (stat.div_done) begin
					cmd.commit = 1'b1;
					if (job_q == nnd_pkg::JOB_ROW_CUR) begin
						state_d = nnd_pkg::ST_RUN;
					end else begin
						job_d   = nnd_pkg::job_t'(job_q + 2'd1);
						state_d = nnd_pkg::ST_START;
					end
				end
			end
			default: begin
				state_d = nnd_pkg::ST_RUN;
			end
		endcase
	end

endmodule

FILE: design/nnd_datapath.sv
// ----------------------------------------------------------------------------
// nnd_datapath
// Size registers, source and destination counters, the incremental
// coordinate mapping with its divider, and the output register.
// ----------------------------------------------------------------------------
module nnd_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nnd_pkg::ctrl_cmd_t            cmd,
	output nnd_pkg::dp_stat_t             stat,
	// Configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [nnd_pkg::IDX_W-1:0]     cfg_index,
	input  logic [nnd_pkg::CFG_W-1:0]     cfg_data,
	// Source pixels
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [nnd_pkg::PIX_W-1:0]     src_pixel,
	// Destination pixels
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [nnd_pkg::PIX_W-1:0]     dst_pixel,
	output logic [nnd_pkg::COORD_W-1:0]   dst_x,
	output logic [nnd_pkg::COORD_W-1:0]   dst_y,
	output logic                          frame_end
);

	localparam int W = nnd_pkg::CFG_W;

	// Size registers and mapping-stale flag
	logic [W-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
	logic         dirty_q;

	// Frame counters
	logic [W-1:0] src_col_q, src_row_q, out_col_q, out_row_q;

	// Mapping: current source column/row wanted, remainders, and steps
	logic [W-1:0] col_q_q, col_r_q, row_q_q, row_r_q;
	logic [W-1:0] col_qs_q, col_rs_q, row_qs_q, row_rs_q;

	// Output register
	logic                          out_valid_q;
	logic [nnd_pkg::PIX_W-1:0]     pix_q;
	logic [nnd_pkg::COORD_W-1:0]   x_q, y_q;
	logic                          last_q;

	// Effective sizes
	logic [W-1:0] sw, sh, dw, dh;

	// Divider
	logic [nnd_pkg::DVD_W-1:0] div_dvd;
	logic [W-1:0]              div_dsr;
	logic                      div_done;
	logic [nnd_pkg::DVD_W-1:0] div_quo;
	logic [W-1:0]              div_rem;

	// Per-pixel decision
	logic         row_live, col_live, row_hit, emit, last_pix;
	logic         take, out_pop;
	logic [W:0]   src_col_inc, src_row_inc;
	logic         row_end, frame_done;
	logic [W:0]   col_r_sum, row_r_sum;
	logic         col_carry, row_carry;
	logic [W-1:0] col_q_nx, col_r_nx, row_q_nx, row_r_nx;

	always_comb begin
		sw = nnd_pkg::clamp_dim(src_width_q, nnd_pkg::MAX_DIM);
		sh = nnd_pkg::clamp_dim(src_height_q, nnd_pkg::MAX_DIM);
		dw = nnd_pkg::clamp_dim(dst_width_q, {{(32-W){1'b0}}, sw});
		dh = nnd_pkg::clamp_dim(dst_height_q, {{(32-W){1'b0}}, sh});
	end

	// Divider operands by job
	always_comb begin
		case (cmd.job)
			nnd_pkg::JOB_COL_STEP: begin
				div_dvd = {{W{1'b0}}, sw};
				div_dsr = dw;
			end
			nnd_pkg::JOB_ROW_STEP: begin
				div_dvd = {{W{1'b0}}, sh};
				div_dsr = dh;
			end
			nnd_pkg::JOB_COL_CUR: begin
				div_dvd = nnd_pkg::DVD_W'(out_col_q) * nnd_pkg::DVD_W'(sw);
				div_dsr = dw;
			end
			nnd_pkg::JOB_ROW_CUR: begin
				div_dvd = nnd_pkg::DVD_W'(out_row_q) * nnd_pkg::DVD_W'(sh);
				div_dsr = dh;
			end
			default: begin
				div_dvd = '0;
				div_dsr = dw;
			end
		endcase
	end

	nnd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Decide the fate of the pixel at the head of the input
	always_comb begin
		row_live    = out_row_q < dh;
		col_live    = out_col_q < dw;
		row_hit     = row_live && (src_row_q == row_q_q);
		emit        = row_hit && col_live && (src_col_q == col_q_q);
		last_pix    = ((out_col_q + W'(1)) == dw) && ((out_row_q + W'(1)) == dh);
		out_pop     = out_valid_q && !out_stall;
		in_stall    = !cmd.run || (emit && out_valid_q && out_stall);
		take        = in_valid && !in_stall;
		src_col_inc = {1'b0, src_col_q} + (W+1)'(1);
		src_row_inc = {1'b0, src_row_q} + (W+1)'(1);
		row_end     = src_col_inc >= {1'b0, sw};
		frame_done  = src_row_inc >= {1'b0, sh};
	end

	// Advance the mapping by one step: add the step, fold the remainder once
	always_comb begin
		col_r_sum = {1'b0, col_r_q} + {1'b0, col_rs_q};
		col_carry = col_r_sum >= {1'b0, dw};
		col_r_nx  = col_carry ? W'(col_r_sum - {1'b0, dw}) : col_r_sum[W-1:0];
		col_q_nx  = col_q_q + col_qs_q + W'(col_carry);
		row_r_sum = {1'b0, row_r_q} + {1'b0, row_rs_q};
		row_carry = row_r_sum >= {1'b0, dh};
		row_r_nx  = row_carry ? W'(row_r_sum - {1'b0, dh}) : row_r_sum[W-1:0];
		row_q_nx  = row_q_q + row_qs_q + W'(row_carry);
	end

	// Size registers; a write to any of the four marks the mapping stale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= nnd_pkg::CFG_RESET;
			src_height_q <= nnd_pkg::CFG_RESET;
			dst_width_q  <= nnd_pkg::CFG_RESET;
			dst_height_q <= nnd_pkg::CFG_RESET;
			dirty_q      <= 1'b1;
		end else begin
			if (cmd.clear_dirty) begin
				dirty_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					nnd_pkg::REG_SRC_WIDTH: begin
						src_width_q <= cfg_data;
						dirty_q     <= 1'b1;
					end
					nnd_pkg::REG_SRC_HEIGHT: begin
						src_height_q <= cfg_data;
						dirty_q      <= 1'b1;
					end
					nnd_pkg::REG_DST_WIDTH: begin
						dst_width_q <= cfg_data;
						dirty_q     <= 1'b1;
					end
					nnd_pkg::REG_DST_HEIGHT: begin
						dst_height_q <= cfg_data;
						dirty_q      <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Counters and mapping: step on each taken pixel, reload from divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			col_q_q   <= '0;
			col_r_q   <= '0;
			row_q_q   <= '0;
			row_r_q   <= '0;
			col_qs_q  <= '0;
			col_rs_q  <= '0;
			row_qs_q  <= '0;
			row_rs_q  <= '0;
		end else if (cmd.commit) begin
			case (cmd.job)
				nnd_pkg::JOB_COL_STEP: begin
					col_qs_q <= div_quo[W-1:0];
					col_rs_q <= div_rem;
				end
				nnd_pkg::JOB_ROW_STEP: begin
					row_qs_q <= div_quo[W-1:0];
					row_rs_q <= div_rem;
				end
				nnd_pkg::JOB_COL_CUR: begin
					col_q_q <= div_quo[W-1:0];
					col_r_q <= div_rem;
				end
				nnd_pkg::JOB_ROW_CUR: begin
					row_q_q <= div_quo[W-1:0];
					row_r_q <= div_rem;
				end
				default: begin
				end
			endcase
		end else if (take) begin
			if (frame_done && row_end) begin
				// Rewind the whole frame
				src_col_q <= '0;
				src_row_q <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				col_q_q   <= '0;
				col_r_q   <= '0;
				row_q_q   <= '0;
				row_r_q   <= '0;
			end else if (row_end) begin
				src_col_q <= '0;
				src_row_q <= src_row_inc[W-1:0];
				if (row_hit) begin
					out_col_q <= '0;
					col_q_q   <= '0;
					col_r_q   <= '0;
					out_row_q <= out_row_q + W'(1);
					row_q_q   <= row_q_nx;
					row_r_q   <= row_r_nx;
				end else if (emit) begin
					out_col_q <= out_col_q + W'(1);
					col_q_q   <= col_q_nx;
					col_r_q   <= col_r_nx;
				end
			end else begin
				src_col_q <= src_col_inc[W-1:0];
				if (emit) begin
					out_col_q <= out_col_q + W'(1);
					col_q_q   <= col_q_nx;
					col_r_q   <= col_r_nx;
				end
			end
		end
	end

	// Output valid: set on an emitted pixel, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (take && emit) begin
			pix_q  <= src_pixel;
			x_q    <= out_col_q[nnd_pkg::COORD_W-1:0];
			y_q    <= out_row_q[nnd_pkg::COORD_W-1:0];
			last_q <= last_pix;
		end
	end

	assign cfg_ready     = 1'b1;
	assign stat.dirty    = dirty_q;
	assign stat.div_done = div_done;
	assign out_valid     = out_valid_q;
	assign dst_pixel     = pix_q;
	assign dst_x         = x_q;
	assign dst_y         = y_q;
	assign frame_end     = last_q;

endmodule

FILE: design/nearest_neighbor_downscaler_core.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_downscaler_core
// Streaming nearest-neighbor downscaler for 32-bit BGRA pixels in raster
// order; passes the source pixel nearest each destination pixel.
// ----------------------------------------------------------------------------
// A source pixel is taken every clock while the mapping is current, and one
// whose result cannot be placed waits only when the output register is full
// and stalled; dropped pixels keep flowing. The mapping from destination to
// source coordinates advances incrementally by a precomputed quotient and
// remainder. After reset, and after any size register write, the block
// rebuilds that mapping with a bit-serial divider run four times (the
// controller first notices the change, then each run has a start state,
// 26 divide steps and a commit) during which no pixel is taken;
// configuration writes are taken at any time. Destination sizes are clamped
// to the source sizes, a size of zero counts as one, and the frame counters
// rewind after the last source pixel of each frame.
// ----------------------------------------------------------------------------
module nearest_neighbor_downscaler_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [nnd_pkg::IDX_W-1:0]     cfg_index,
	input  logic [nnd_pkg::CFG_W-1:0]     cfg_data,
	// Source pixels
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [nnd_pkg::PIX_W-1:0]     src_pixel,
	// Destination pixels
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [nnd_pkg::PIX_W-1:0]     dst_pixel,
	output logic [nnd_pkg::COORD_W-1:0]   dst_x,
	output logic [nnd_pkg::COORD_W-1:0]   dst_y,
	output logic                          frame_end
);

	nnd_pkg::ctrl_cmd_t cmd;
	nnd_pkg::dp_stat_t  stat;

	// Sequence the mapping rebuilds
	nnd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Counters, mapping and output register
	nnd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.src_pixel (src_pixel),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dst_pixel (dst_pixel),
		.dst_x     (dst_x),
		.dst_y     (dst_y),
		.frame_end (frame_end)
	);

endmodule
